[design/pwft_pkg.sv]
package pwft_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 16;

    localparam int TICK_W  = 6;
    localparam int LEN_W   = 5;
    localparam int BITS_W  = 4;
    localparam int INDEX_W = 4;

    localparam logic [TICK_W-1:0] PREAMBLE_START = 6'd1;
    localparam logic [TICK_W-1:0] PREAMBLE_END   = 6'd21;
    localparam logic [TICK_W:0]   ZERO_LOW_TICKS = 7'd3;
    localparam logic [BITS_W-1:0] BITS_PER_BYTE  = 4'd8;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_START = 2'd2
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [INDEX_W-1:0] byte_index;
        logic [7:0]         byte_value;
        logic [LEN_W-1:0]   frame_length;
    } item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } result_t;

    typedef struct packed {
        logic               en;
        logic [INDEX_W-1:0] index;
        logic [7:0]         value;
    } wr_req_t;

endpackage

[design/pwft_buffer.sv]
module pwft_buffer #(
    parameter int BUFFER_DEPTH = pwft_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic                          clk,
    input  pwft_pkg::wr_req_t             wr,
    input  logic [pwft_pkg::LEN_W-1:0]    rd_index,
    output logic [7:0]                    rd_data
);
    import pwft_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [7:0] buffer_reg [BUFFER_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            buffer_reg[AW'(wr.index)] <= wr.value;
        end
        rd_data_reg <= buffer_reg[AW'(rd_index)];
    end

    assign rd_data = rd_data_reg;

endmodule

[design/pwft_core.sv]
module pwft_core #(
    parameter int BUFFER_DEPTH = pwft_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  pwft_pkg::item_t               item,
    input  logic [7:0]                    rd_data,
    output pwft_pkg::wr_req_t             wr,
    output logic [pwft_pkg::LEN_W-1:0]    rd_index,
    output pwft_pkg::result_t             result_next
);
    import pwft_pkg::*;

    logic              sending_reg,        sending_next;
    logic [TICK_W-1:0] tick_count_reg,     tick_count_next;
    logic              low_phase_reg,      low_phase_next;
    logic [TICK_W-1:0] low_start_mark_reg, low_start_mark_next;
    logic [7:0]        shift_byte_reg,     shift_byte_next;
    logic [7:0]        cur_byte_reg,       cur_byte_next;
    logic [7:0]        running_sum_reg,    running_sum_next;
    logic [BITS_W-1:0] bits_sent_reg,      bits_sent_next;
    logic [LEN_W-1:0]  byte_pointer_reg,   byte_pointer_next;
    logic [LEN_W-1:0]  length_in_use_reg,  length_in_use_next;
    logic              wire_level_reg,     wire_level_next;

    logic [TICK_W-1:0] tick_inc;
    logic [LEN_W-1:0]  ptr_inc;
    logic [7:0]        sum_add;
    logic              done;

    assign tick_inc = tick_count_reg + 1'b1;
    assign ptr_inc  = byte_pointer_reg + 1'b1;
    assign sum_add  = running_sum_reg + cur_byte_reg;

    always_comb
    begin
        sending_next        = sending_reg;
        tick_count_next     = tick_count_reg;
        low_phase_next      = low_phase_reg;
        low_start_mark_next = low_start_mark_reg;
        shift_byte_next     = shift_byte_reg;
        cur_byte_next       = cur_byte_reg;
        running_sum_next    = running_sum_reg;
        bits_sent_next      = bits_sent_reg;
        byte_pointer_next   = byte_pointer_reg;
        length_in_use_next  = length_in_use_reg;
        wire_level_next     = wire_level_reg;
        done                = 1'b0;
        wr.en               = 1'b0;
        wr.index            = item.byte_index;
        wr.value            = item.byte_value;

        if (accept)
        begin
            case (item.action)
                ACT_TICK:
                begin
                    if (sending_reg)
                    begin
                        tick_count_next = tick_inc;
                        if (tick_inc == PREAMBLE_START)
                        begin
                            wire_level_next  = 1'b0;
                            shift_byte_next  = rd_data;
                            cur_byte_next    = rd_data;
                            running_sum_next = 8'd0;
                        end
                        else if (tick_inc == PREAMBLE_END)
                        begin
                            wire_level_next = 1'b1;
                        end
                        else if (tick_inc > PREAMBLE_END)
                        begin
                            if (!low_phase_reg)
                            begin
                                wire_level_next     = 1'b0;
                                low_phase_next      = 1'b1;
                                low_start_mark_next = tick_inc;
                            end
                            else
                            begin
                                // a one ends after a single low tick, a zero after three
                                if (shift_byte_reg[0] ||
                                    ({1'b0, tick_inc} ==
                                     {1'b0, low_start_mark_reg} + ZERO_LOW_TICKS))
                                begin
                                    wire_level_next = 1'b1;
                                    low_phase_next  = 1'b0;
                                    shift_byte_next = {1'b0, shift_byte_reg[7:1]};
                                    bits_sent_next  = bits_sent_reg + 1'b1;
                                end
                                if (bits_sent_next == BITS_PER_BYTE)
                                begin
                                    bits_sent_next    = '0;
                                    byte_pointer_next = ptr_inc;
                                    if (ptr_inc < length_in_use_reg)
                                    begin
                                        tick_count_next  = PREAMBLE_END;
                                        running_sum_next = sum_add;
                                        // last byte of the frame carries the sum
                                        if ({1'b0, ptr_inc} + 1'b1 < {1'b0, length_in_use_reg})
                                        begin
                                            shift_byte_next = rd_data;
                                            cur_byte_next   = rd_data;
                                        end
                                        else
                                        begin
                                            shift_byte_next = sum_add;
                                        end
                                    end
                                    else
                                    begin
                                        sending_next      = 1'b0;
                                        tick_count_next   = '0;
                                        byte_pointer_next = '0;
                                        done              = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                ACT_WRITE:
                begin
                    if (!sending_reg && (int'(item.byte_index) < BUFFER_DEPTH))
                    begin
                        wr.en = 1'b1;
                    end
                end
                ACT_START:
                begin
                    if (!sending_reg)
                    begin
                        if (item.frame_length == '0)
                        begin
                            length_in_use_next = LEN_W'(1);
                        end
                        else if (int'(item.frame_length) > BUFFER_DEPTH)
                        begin
                            length_in_use_next = LEN_W'(BUFFER_DEPTH);
                        end
                        else
                        begin
                            length_in_use_next = item.frame_length;
                        end
                        sending_next      = 1'b1;
                        tick_count_next   = '0;
                        low_phase_next    = 1'b0;
                        bits_sent_next    = '0;
                        byte_pointer_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // prefetch byte 0 before the frame opens, otherwise the byte after the current one
    assign rd_index = (tick_count_next == '0) ? '0 : byte_pointer_next + 1'b1;

    assign result_next.line_level = wire_level_next;
    assign result_next.busy_res   = sending_next;
    assign result_next.frame_done = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg        <= 1'b0;
            tick_count_reg     <= '0;
            low_phase_reg      <= 1'b0;
            low_start_mark_reg <= '0;
            shift_byte_reg     <= '0;
            cur_byte_reg       <= '0;
            running_sum_reg    <= '0;
            bits_sent_reg      <= '0;
            byte_pointer_reg   <= '0;
            length_in_use_reg  <= LEN_W'(1);
            wire_level_reg     <= 1'b1;
        end
        else
        begin
            sending_reg        <= sending_next;
            tick_count_reg     <= tick_count_next;
            low_phase_reg      <= low_phase_next;
            low_start_mark_reg <= low_start_mark_next;
            shift_byte_reg     <= shift_byte_next;
            cur_byte_reg       <= cur_byte_next;
            running_sum_reg    <= running_sum_next;
            bits_sent_reg      <= bits_sent_next;
            byte_pointer_reg   <= byte_pointer_next;
            length_in_use_reg  <= length_in_use_next;
            wire_level_reg     <= wire_level_next;
        end
    end

endmodule

[design/pulse_width_frame_transmitter_unit.sv]
// Single-wire pulse-width frame transmitter. Each request is a tick, a buffer
// write or a frame start, and each gives exactly one result: the wire level,
// the busy flag and a done flag on the tick that ends a frame. A request is
// taken in every clock cycle while the result register is empty or being
// drained, and its result appears in the result register in the next cycle;
// the next state is one pass of counter and compare logic, and the frame
// buffer is a small memory with one write port and one registered read port
// that fetches the next byte ahead of its use.
module pulse_width_frame_transmitter_unit #(
    parameter int BUFFER_DEPTH = pwft_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  pwft_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output pwft_pkg::result_t result
);
    import pwft_pkg::*;

    logic             accept;
    wr_req_t          wr;
    logic [LEN_W-1:0] rd_index;
    logic [7:0]       rd_data;
    result_t          result_next;
    result_t          result_reg;
    logic             result_valid_reg;

    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    pwft_buffer #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_buffer (
        .clk      (clk),
        .wr       (wr),
        .rd_index (rd_index),
        .rd_data  (rd_data)
    );

    pwft_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .rd_data     (rd_data),
        .wr          (wr),
        .rd_index    (rd_index),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            result_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
